[rtl/rmq_pkg.sv]
// shared types and constants for the rotation matrix to quaternion block
`default_nettype none
package rmq_pkg;

  localparam int XW = 32;

  typedef enum logic [1:0] {
    HS_W = 2'd0,
    HS_X = 2'd1,
    HS_Y = 2'd2,
    HS_Z = 2'd3
  } half_slot_t;

  typedef struct packed {
    logic signed [XW-1:0] m11;
    logic signed [XW-1:0] m12;
    logic signed [XW-1:0] m13;
    logic signed [XW-1:0] m21;
    logic signed [XW-1:0] m22;
    logic signed [XW-1:0] m23;
    logic signed [XW-1:0] m31;
    logic signed [XW-1:0] m32;
    logic signed [XW-1:0] m33;
  } rmq_in_t;

  typedef struct packed {
    logic signed [XW-1:0] quat_w;
    logic signed [XW-1:0] quat_x;
    logic signed [XW-1:0] quat_y;
    logic signed [XW-1:0] quat_z;
    logic                 bad_input;
  } rmq_out_t;

endpackage
`default_nettype wire

[rtl/rmq_sqrt.sv]
// pipelined integer square root, one result bit per stage
`default_nettype none
module rmq_sqrt #(
  parameter int SW = 32,
  parameter int TW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [2*SW-1:0] in_rad,
  input  wire logic [TW-1:0]   in_tag,
  output logic                 out_valid,
  output logic [SW-1:0]        out_root,
  output logic [TW-1:0]        out_tag
);

  localparam int RW = 2 * SW;

  logic [RW-1:0] rem_r  [SW];
  logic [SW-1:0] root_r [SW];
  logic [TW-1:0] tag_r  [SW];
  logic          vld_r  [SW];

  genvar k;
  generate
    for (k = 0; k < SW; k++) begin : g_stage
      localparam int B = SW - 1 - k;
      logic [RW-1:0] rem_in;
      logic [SW-1:0] root_in;
      logic [TW-1:0] tag_in;
      logic          vld_in;
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_nxt;
      logic [SW-1:0] root_nxt;

      if (k == 0) begin : g_first
        assign rem_in  = in_rad;
        assign root_in = '0;
        assign tag_in  = in_tag;
        assign vld_in  = in_valid;
      end else begin : g_next
        assign rem_in  = rem_r[k-1];
        assign root_in = root_r[k-1];
        assign tag_in  = tag_r[k-1];
        assign vld_in  = vld_r[k-1];
      end

      always_comb begin
        trial    = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
        rem_nxt  = rem_in;
        root_nxt = root_in;
        if (rem_in >= trial) begin
          rem_nxt  = rem_in - trial;
          root_nxt = root_in | (SW'(1) << B);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= rem_nxt;
          root_r[k] <= root_nxt;
          tag_r[k]  <= tag_in;
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[SW-1];
  assign out_root  = root_r[SW-1];
  assign out_tag   = tag_r[SW-1];

endmodule
`default_nettype wire

[rtl/rmq_div.sv]
// three-lane pipelined divider with saturation detect, then one quotient bit per quotient stage
`default_nettype none
module rmq_div #(
  parameter int W  = 32,
  parameter int F  = 30,
  parameter int SW = 32,
  parameter int TW = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [2:0][W:0]   in_num,
  input  wire logic [SW-1:0]     in_root,
  input  wire logic [TW-1:0]     in_tag,
  output logic                   out_valid,
  output logic [2:0]             out_neg,
  output logic [2:0]             out_ovf,
  output logic [2:0][W-2:0]      out_quo,
  output logic [TW-1:0]          out_tag
);

  localparam int NW = SW + W + 1;
  localparam int NS = W;

  logic [2:0][NW-1:0] rem_r [NS];
  logic [NW-1:0]      d_r   [NS];
  logic [2:0]         neg_r [NS];
  logic [2:0]         ovf_r [NS];
  logic [2:0][W-2:0]  quo_r [NS];
  logic [TW-1:0]      tag_r [NS];
  logic               vld_r [NS];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      logic [2:0][NW-1:0] rem_nxt;
      logic [NW-1:0]      d_nxt;
      logic [2:0]         neg_nxt;
      logic [2:0]         ovf_nxt;
      logic [2:0][W-2:0]  quo_nxt;
      logic [TW-1:0]      tag_in;
      logic               vld_in;

      if (k == 0) begin : g_prep
        logic signed [W+1:0] ext [3];
        logic [W+1:0]        mag [3];
        logic [SW-1:0]       sx;

        assign tag_in = in_tag;
        assign vld_in = in_valid;

        always_comb begin
          sx    = (in_root == '0) ? SW'(1) : in_root;
          d_nxt = NW'(sx) << 1;
          for (int l = 0; l < 3; l++) begin
            ext[l]     = {in_num[l][W], in_num[l]};
            neg_nxt[l] = in_num[l][W];
            mag[l]     = neg_nxt[l] ? $unsigned(-ext[l]) : $unsigned(ext[l]);
            rem_nxt[l] = NW'(mag[l]) << F;
            ovf_nxt[l] = rem_nxt[l] >= (d_nxt << (W - 1));
            quo_nxt[l] = '0;
          end
        end
      end else begin : g_bit
        localparam int B = W - 1 - k;
        logic [NW-1:0] t;

        assign tag_in = tag_r[k-1];
        assign vld_in = vld_r[k-1];

        always_comb begin
          t       = d_r[k-1] << B;
          d_nxt   = d_r[k-1];
          neg_nxt = neg_r[k-1];
          ovf_nxt = ovf_r[k-1];
          for (int l = 0; l < 3; l++) begin
            rem_nxt[l] = rem_r[k-1][l];
            quo_nxt[l] = quo_r[k-1][l];
            if (rem_r[k-1][l] >= t) begin
              rem_nxt[l] = rem_r[k-1][l] - t;
              quo_nxt[l] = quo_r[k-1][l] | ((W-1)'(1) << B);
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          d_r[k]   <= d_nxt;
          neg_r[k] <= neg_nxt;
          ovf_r[k] <= ovf_nxt;
          quo_r[k] <= quo_nxt;
          tag_r[k] <= tag_in;
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[NS-1];
  assign out_neg   = neg_r[NS-1];
  assign out_ovf   = ovf_r[NS-1];
  assign out_quo   = quo_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule
`default_nettype wire

[rtl/rotation_matrix_to_quaternion_top.sv]
// top level: rotation matrix to unit quaternion, Shepperd branch selection
//
// usage
//   input channel in_valid / in_stall / in_data carries one 3x3 matrix per
//   transaction, nine signed fixed point elements; only the low WORD_BITS bits
//   of each element are used
//   result channel out_valid / out_stall / out_data returns quat_w..quat_z
//   and bad_input, one result transaction per input transaction, in order
//   the pipeline is one setup stage, one square root stage per root bit,
//   one divider stage per quotient bit plus a saturation check, and the
//   output register
//   throughput is one transaction per cycle while out_stall does not hold
//   the pipeline; every stage is a register stage
//   reset clears all valid bits so the pipeline comes up empty
//   while a result waits under out_stall the whole pipeline holds and
//   in_stall is raised; nothing is dropped or repeated
`default_nettype none
module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = 30,
  parameter int WORD_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire rmq_pkg::rmq_in_t in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output rmq_pkg::rmq_out_t    out_data
);

  localparam int W    = WORD_BITS;
  localparam int SW   = (WORD_BITS + FRAC_BITS + 3) / 2;
  localparam int RW   = 2 * SW;
  localparam int EW   = WORD_BITS + 3;
  localparam int NTW  = 3 + 3 * (W + 1);
  localparam int DTW  = 3 + W;
  localparam int CW   = SW + W;
  localparam logic signed [EW-1:0] ONE = EW'(1) << FRAC_BITS;

  logic en;

  // setup stage
  logic signed [W-1:0]  a11, a12, a13, a21, a22, a23, a31, a32, a33;
  logic signed [EW-1:0] e11, e22, e33, tr, rr;
  logic signed [W:0]    d32_23, d13_31, d21_12, s12_21, s31_13, s23_32;
  rmq_pkg::half_slot_t  hs;
  logic                 bad;
  logic [2:0][W:0]      num;
  logic [RW-1:0]        rad;

  always_comb begin
    a11 = $signed(in_data.m11[W-1:0]);
    a12 = $signed(in_data.m12[W-1:0]);
    a13 = $signed(in_data.m13[W-1:0]);
    a21 = $signed(in_data.m21[W-1:0]);
    a22 = $signed(in_data.m22[W-1:0]);
    a23 = $signed(in_data.m23[W-1:0]);
    a31 = $signed(in_data.m31[W-1:0]);
    a32 = $signed(in_data.m32[W-1:0]);
    a33 = $signed(in_data.m33[W-1:0]);
    e11 = EW'(a11);
    e22 = EW'(a22);
    e33 = EW'(a33);
    tr  = e11 + e22 + e33;
    d32_23 = (W+1)'(a32) - (W+1)'(a23);
    d13_31 = (W+1)'(a13) - (W+1)'(a31);
    d21_12 = (W+1)'(a21) - (W+1)'(a12);
    s12_21 = (W+1)'(a12) + (W+1)'(a21);
    s31_13 = (W+1)'(a31) + (W+1)'(a13);
    s23_32 = (W+1)'(a23) + (W+1)'(a32);
    if (!tr[EW-1]) begin
      hs = rmq_pkg::HS_W;
    end else begin
      hs = rmq_pkg::HS_X;
      if (a22 > a11) begin
        hs = rmq_pkg::HS_Y;
      end
      if (a33 > ((hs == rmq_pkg::HS_Y) ? a22 : a11)) begin
        hs = rmq_pkg::HS_Z;
      end
    end
    case (hs)
      rmq_pkg::HS_W: begin
        rr  = tr + ONE;
        num = {d21_12, d13_31, d32_23};
      end
      rmq_pkg::HS_X: begin
        rr  = e11 - e22 - e33 + ONE;
        num = {s31_13, s12_21, d32_23};
      end
      rmq_pkg::HS_Y: begin
        rr  = e22 - e33 - e11 + ONE;
        num = {s23_32, s12_21, d13_31};
      end
      default: begin
        rr  = e33 - e11 - e22 + ONE;
        num = {s23_32, s31_13, d21_12};
      end
    endcase
    bad = rr[EW-1] || (rr == '0);
    rad = bad ? '0 : (RW'($unsigned(rr)) << FRAC_BITS);
  end

  logic            s0_vld_r;
  logic [RW-1:0]   s0_rad_r;
  logic [NTW-1:0]  s0_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_rad_r <= rad;
      s0_tag_r <= {hs, bad, num};
    end
  end

  // square root
  logic            sq_vld;
  logic [SW-1:0]   sq_root;
  logic [NTW-1:0]  sq_tag;

  rmq_sqrt #(.SW(SW), .TW(NTW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_vld_r),
    .in_rad    (s0_rad_r),
    .in_tag    (s0_tag_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  logic [2:0][W:0] sq_num;
  logic [CW-1:0]   half_ext;
  logic [W-1:0]    half;

  always_comb begin
    sq_num   = sq_tag[3*(W+1)-1:0];
    half_ext = CW'(sq_root >> 1);
    if (half_ext >= (CW'(1) << (W - 1))) begin
      half = {1'b0, {(W-1){1'b1}}};
    end else begin
      half = half_ext[W-1:0];
    end
  end

  // division
  logic            dv_vld;
  logic [2:0]      dv_neg;
  logic [2:0]      dv_ovf;
  logic [2:0][W-2:0] dv_quo;
  logic [DTW-1:0]  dv_tag;

  rmq_div #(.W(W), .F(FRAC_BITS), .SW(SW), .TW(DTW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_vld),
    .in_num    (sq_num),
    .in_root   (sq_root),
    .in_tag    ({sq_tag[NTW-1:NTW-3], half}),
    .out_valid (dv_vld),
    .out_neg   (dv_neg),
    .out_ovf   (dv_ovf),
    .out_quo   (dv_quo),
    .out_tag   (dv_tag)
  );

  // output assembly
  rmq_pkg::half_slot_t dv_hs;
  logic                dv_bad;
  logic [W-1:0]        dv_half;
  logic [1:0]          hsi;
  logic [1:0]          ln;
  logic signed [W-1:0] lane_val [3];
  logic signed [W-1:0] slot_val [4];
  rmq_pkg::rmq_out_t   out_data_nxt;

  always_comb begin
    dv_hs   = rmq_pkg::half_slot_t'(dv_tag[DTW-1:DTW-2]);
    dv_bad  = dv_tag[W];
    dv_half = dv_tag[W-1:0];
    hsi     = dv_tag[DTW-1:DTW-2];
    for (int l = 0; l < 3; l++) begin
      if (dv_ovf[l]) begin
        lane_val[l] = dv_neg[l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else if (dv_neg[l]) begin
        lane_val[l] = -$signed({1'b0, dv_quo[l]});
      end else begin
        lane_val[l] = $signed({1'b0, dv_quo[l]});
      end
    end
    for (int k = 0; k < 4; k++) begin
      ln = (2'(k) < hsi) ? 2'(k) : 2'(k - 1);
      if (dv_bad) begin
        slot_val[k] = '0;
      end else if (2'(k) == hsi) begin
        slot_val[k] = $signed(dv_half);
      end else begin
        slot_val[k] = lane_val[ln];
      end
    end
    out_data_nxt.quat_w    = rmq_pkg::XW'(slot_val[0]);
    out_data_nxt.quat_x    = rmq_pkg::XW'(slot_val[1]);
    out_data_nxt.quat_y    = rmq_pkg::XW'(slot_val[2]);
    out_data_nxt.quat_z    = rmq_pkg::XW'(slot_val[3]);
    out_data_nxt.bad_input = dv_bad && (dv_hs != rmq_pkg::HS_W || dv_bad);
  end

  logic              out_valid_r;
  rmq_pkg::rmq_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign in_stall  = out_valid_r && out_stall;
  assign en        = !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_input |->
      out_data.quat_w == '0 && out_data.quat_x == '0 &&
      out_data.quat_y == '0 && out_data.quat_z == '0)
    else $error("bad input result carries a nonzero component");

  a_one_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.bad_input |->
      !(out_data.quat_w[rmq_pkg::XW-1] && out_data.quat_x[rmq_pkg::XW-1] &&
        out_data.quat_y[rmq_pkg::XW-1] && out_data.quat_z[rmq_pkg::XW-1]))
    else $error("all quaternion components negative");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule
`default_nettype wire
